FILE: rtl/ssort_pkg.sv
// Shared types for the selection sorter: the word that moves between cells
// and the controller state. No dependencies.
package ssort_pkg;

   localparam int unsigned WORD_WIDTH = 32;

   typedef struct packed {
      logic                         valid;
      logic signed [WORD_WIDTH-1:0] value;
   } slot_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SETTLE,
      ST_DRAIN
   } state_type;

endpackage

FILE: rtl/ssort_cell.sv
// One cell of the sorting chain: keeps the smaller of its word and the
// incoming word, passes the larger on; shifts toward the head when draining.
// Depends on ssort_pkg.
module ssort_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              shift,
   input  ssort_pkg::slot_type left_in,
   input  ssort_pkg::slot_type right_slot,
   output ssort_pkg::slot_type pass_out,
   output ssort_pkg::slot_type held_out
);
   import ssort_pkg::*;

   slot_type held_ff, held_in;
   slot_type pass_ff, pass_in;

   always_comb begin
      held_in       = held_ff;
      pass_in.valid = 1'b0;
      pass_in.value = left_in.value;
      if (shift) begin
         held_in = right_slot;
      end else if (left_in.valid) begin
         if (!held_ff.valid) begin
            held_in = left_in;
         end else if (left_in.value < held_ff.value) begin
            held_in = left_in;
            pass_in = held_ff;
         end else begin
            pass_in = left_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff.valid <= 1'b0;
         pass_ff.valid <= 1'b0;
      end else begin
         held_ff <= held_in;
         pass_ff <= pass_in;
      end
   end

   assign pass_out = pass_ff;
   assign held_out = held_ff;

endmodule

FILE: rtl/ssort_ctrl.sv
// Load / settle / drain sequencer for the sorter: counts words, tracks
// overflow and times the chain. Depends on ssort_pkg.
module ssort_ctrl #(
   parameter int unsigned DEPTH = 32
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_last,
   input  logic rsp_ready,
   output logic req_ready,
   output logic inject,
   output logic rsp_valid,
   output logic rsp_last,
   output logic rsp_dropped,
   output logic shift
);
   import ssort_pkg::*;

   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam int unsigned SW = $clog2(DEPTH);

   state_type      state_ff, state_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [SW-1:0]  settle_ff, settle_in;
   logic           over_ff, over_in;
   logic           take, room, give;

   assign room = count_ff < CW'(DEPTH);
   assign take = req_valid && req_ready;
   assign give = rsp_valid && rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD:   if (take && req_last) state_in = ST_SETTLE;
         ST_SETTLE: if (settle_ff == SW'(DEPTH - 1)) state_in = ST_DRAIN;
         ST_DRAIN:  if (give && count_ff == CW'(1)) state_in = ST_LOAD;
         default:   state_in = ST_LOAD;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_LOAD:   req_ready = 1'b1;
         ST_SETTLE: ;
         ST_DRAIN:  rsp_valid = 1'b1;
         default:   ;
      endcase
   end

   assign inject      = take && room;
   assign shift       = give;
   assign rsp_last    = count_ff == CW'(1);
   assign rsp_dropped = over_ff;

   always_comb begin
      count_in  = count_ff;
      over_in   = over_ff;
      settle_in = '0;
      if (inject) count_in = count_ff + CW'(1);
      if (take && !room) over_in = 1'b1;
      if (state_ff == ST_SETTLE) settle_in = settle_ff + SW'(1);
      if (give) begin
         count_in = count_ff - CW'(1);
         if (count_ff == CW'(1)) over_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_LOAD;
         count_ff  <= '0;
         over_ff   <= 1'b0;
         settle_ff <= '0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         over_ff   <= over_in;
         settle_ff <= settle_in;
      end
   end

endmodule

FILE: rtl/selection_sorter.sv
// Selection sorter top level: a chain of DEPTH compare cells and a sequencer.
// Depends on ssort_pkg, ssort_cell and ssort_ctrl.
//
// Usage: send the words of a set on the req_ channel, one per cycle while
// req_ready is high; req_in_last marks the final word. Words beyond DEPTH are
// discarded and every result of that set carries rsp_dropped.
// Each accepted word enters the head cell, which keeps the smaller value and
// passes the larger one cell onward per cycle, so the chain holds the set in
// ascending order from the head.
// After the last word, req_ready stays low while the chain settles; results
// then leave the head cell in ascending order, one per cycle when rsp_ready
// is high, the final one with rsp_out_last.
// A set thus passes through load, settle and drain in turn; the settle time
// is the travel of a word down the chain.
// A stalled receiver simply holds the head word; the chain shifts only on an
// accepted result. Reset empties the chain and returns to loading.
module selection_sorter #(
   parameter int unsigned DEPTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic signed [ssort_pkg::WORD_WIDTH-1:0] req_in_value,
   input  logic                            req_in_last,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [ssort_pkg::WORD_WIDTH-1:0] rsp_out_value,
   output logic                            rsp_out_last,
   output logic                            rsp_dropped
);
   import ssort_pkg::*;

   slot_type carry [DEPTH+1];
   slot_type held  [DEPTH+1];
   logic     inject, shift;

   assign carry[0].valid = inject;
   assign carry[0].value = req_in_value;
   assign held[DEPTH].valid = 1'b0;
   assign held[DEPTH].value = '0;

   ssort_ctrl #(.DEPTH(DEPTH)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_last    (req_in_last),
      .rsp_ready   (rsp_ready),
      .req_ready   (req_ready),
      .inject      (inject),
      .rsp_valid   (rsp_valid),
      .rsp_last    (rsp_out_last),
      .rsp_dropped (rsp_dropped),
      .shift       (shift)
   );

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      ssort_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift      (shift),
         .left_in    (carry[i]),
         .right_slot (held[i+1]),
         .pass_out   (carry[i+1]),
         .held_out   (held[i])
      );
   end

   assign rsp_out_value = held[0].value;

endmodule

FILE: test/tb_top.sv
// Self-checking bench for selection_sorter: random and corner-value sets in,
// sorted words checked against a software selection sort in a scoreboard.
// Depends on ssort_pkg and selection_sorter.
`timescale 1ns / 100ps

typedef logic signed [ssort_pkg::WORD_WIDTH-1:0] word_type;

typedef struct packed {
   word_type value;
   logic     last;
   logic     dropped;
} sorted_word_type;

class sort_scoreboard #(int unsigned CAPACITY = 32);
   word_type        loaded_set[$];
   bit              overflowed;
   sorted_word_type sorted_words[$];
   int unsigned     error_count;

   function void note_word(word_type value, logic last);
      int              pos;
      int              k;
      int              min_at;
      word_type        min_val;
      sorted_word_type w;
      if (loaded_set.size() < CAPACITY) begin
         loaded_set.push_back(value);
      end else begin
         overflowed = 1'b1;
      end
      if (!last) begin
         return;
      end
      for (pos = 0; pos + 1 < loaded_set.size(); pos++) begin
         min_at  = pos;
         min_val = loaded_set[pos];
         for (k = pos + 1; k < loaded_set.size(); k++) begin
            if (loaded_set[k] < min_val) begin
               min_val = loaded_set[k];
               min_at  = k;
            end
         end
         loaded_set[min_at] = loaded_set[pos];
         loaded_set[pos]    = min_val;
      end
      for (k = 0; k < loaded_set.size(); k++) begin
         w.value   = loaded_set[k];
         w.last    = (k + 1 == loaded_set.size());
         w.dropped = overflowed;
         sorted_words.push_back(w);
      end
      loaded_set.delete();
      overflowed = 1'b0;
   endfunction

   function void check_word(word_type value, logic last, logic dropped);
      sorted_word_type w;
      if (sorted_words.size() == 0) begin
         $display("%0t: unexpected word, actual value %0d last %0b dropped %0b",
                  $time, value, last, dropped);
         error_count++;
         return;
      end
      w = sorted_words.pop_front();
      if (value !== w.value) begin
         $display("%0t: out_value mismatch, expected %0d, actual %0d",
                  $time, w.value, value);
         error_count++;
      end
      if (last !== w.last) begin
         $display("%0t: out_last mismatch, expected %0b, actual %0b",
                  $time, w.last, last);
         error_count++;
      end
      if (dropped !== w.dropped) begin
         $display("%0t: dropped mismatch, expected %0b, actual %0b",
                  $time, w.dropped, dropped);
         error_count++;
      end
   endfunction
endclass

module tb_top;
   localparam int unsigned DEPTH      = 32;
   localparam int unsigned QUIET_MAX  = 2000;
   localparam word_type    WORD_MAX   = 32'sh7fffffff;
   localparam word_type    WORD_MIN   = 32'sh80000000;

   logic     clock;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_ready;
   word_type req_in_value = '0;
   logic     req_in_last = 1'b0;
   logic     rsp_valid;
   logic     rsp_ready = 1'b0;
   word_type rsp_out_value;
   logic     rsp_out_last;
   logic     rsp_dropped;

   int unsigned idle_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned quiet_cycles = 0;

   sort_scoreboard #(DEPTH) sb;

   selection_sorter #(.DEPTH(DEPTH)) uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_in_value  (req_in_value),
      .req_in_last   (req_in_last),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_value (rsp_out_value),
      .rsp_out_last  (rsp_out_last),
      .rsp_dropped   (rsp_dropped)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_ready <= reset ? 1'b0 : ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_word(rsp_out_value, rsp_out_last, rsp_dropped);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_MAX) begin
            $display("tb_top: done, errors");
            $finish;
         end
      end
   end

   function automatic word_type pick_value();
      case ($urandom_range(7))
         0, 1: return word_type'(int'($urandom_range(8)) - 4);
         2: begin
            case ($urandom_range(3))
               0: return WORD_MAX;
               1: return WORD_MIN;
               2: return '0;
               default: return '1;
            endcase
         end
         default: return word_type'($urandom);
      endcase
   endfunction

   // entered and left at a falling edge
   task automatic send_word(input word_type value, input logic last);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_in_value <= value;
      req_in_last  <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_word(value, last);
      @(negedge clock);
   endtask

   task automatic send_set(input int unsigned size);
      for (int unsigned i = 0; i < size; i++) begin
         send_word(pick_value(), i + 1 == size);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (sb.sorted_words.size() != 0) @(negedge clock);
   endtask

   initial begin
      word_type    corner_set[7];
      word_type    dup_set[5];
      int unsigned sent;
      int unsigned size;
      sb = new();
      corner_set = '{WORD_MAX, WORD_MIN, 32'sd0, -32'sd1, 32'sd1,
                     WORD_MIN + 32'sd1, WORD_MAX - 32'sd1};
      dup_set = '{32'sd7, -32'sd7, 32'sd7, -32'sd7, 32'sd7};
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // sets of one, corner values, descending run, repeated values
      send_word(WORD_MAX, 1'b1);
      send_word(WORD_MIN, 1'b1);
      foreach (corner_set[i]) send_word(corner_set[i], i == 6);
      for (int i = 3; i >= 0; i--) send_word(word_type'(i), i == 0);
      foreach (dup_set[i]) send_word(dup_set[i], i == 4);
      wait_drained();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct <= 0;  end
            1: begin idle_pct = 66; stall_pct <= 0;  end
            2: begin idle_pct = 0;  stall_pct <= 66; end
            default: begin idle_pct = 31; stall_pct <= 31; end
         endcase
         if (phase == 1) begin
            send_set(DEPTH + $urandom_range(1, 3));
         end
         if (phase == 3) begin
            send_set(DEPTH);
         end
         sent = 0;
         while (sent < 8) begin
            size = ($urandom_range(5) == 0) ? 1 : $urandom_range(2, 8);
            send_set(size);
            sent += size;
         end
         wait_drained();
      end

      repeat (2 * DEPTH + 8) @(posedge clock);
      if (sb.error_count == 0 && sb.sorted_words.size() == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end
endmodule
